### sv/kuf_pkg.sv
// ----------------------------------------------------------------------------
// kuf_pkg
// Shared types and constants for the Kruskal union-find edge filter.
// ----------------------------------------------------------------------------
`default_nettype none

package kuf_pkg;

  localparam int NODE_W  = 10;
  localparam int COST_W  = 32;
  localparam int COUNT_W = 11;
  localparam int TOTAL_W = 48;

  localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;

  // command codes on the input channel
  localparam logic CMD_EDGE  = 1'b0;
  localparam logic CMD_CLEAR = 1'b1;

  // classification made by the front end
  typedef enum logic [1:0] {
    OP_EDGE,
    OP_BAD,
    OP_CLEAR
  } op_t;

  typedef struct packed {
    op_t               op;
    logic [NODE_W-1:0] node_a;
    logic [NODE_W-1:0] node_b;
    logic [COST_W-1:0] cost;
  } item_t;

endpackage

`default_nettype wire

### sv/kuf_front.sv
// ----------------------------------------------------------------------------
// kuf_front
// Accepts input items, classifies them, and queues them for the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module kuf_front #(
  parameter int COST_BITS = 32
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        in_valid,
  output      logic                        in_ready,
  input  wire logic                        cmd,
  input  wire logic [kuf_pkg::NODE_W-1:0]  node_a,
  input  wire logic [kuf_pkg::NODE_W-1:0]  node_b,
  input  wire logic [kuf_pkg::COST_W-1:0]  edge_cost,
  input  wire logic [kuf_pkg::COUNT_W-1:0] node_count,
  output      logic                        q_valid,
  output      kuf_pkg::item_t              q_item,
  input  wire logic                        q_pop
);
  import kuf_pkg::*;

  localparam int CB = (COST_BITS < COST_W) ? COST_BITS : COST_W;
  localparam logic [COST_W-1:0] COST_MASK = COST_W'((64'(1) << CB) - 64'(1));

  item_t       slot [2];
  logic        wr_ptr;
  logic        rd_ptr;
  logic [1:0]  fill;
  item_t       cls;
  logic        push;

  assign in_ready = (fill != 2'd2);
  assign push     = in_valid && in_ready;
  assign q_valid  = (fill != 2'd0);
  assign q_item   = slot[rd_ptr];

  always_comb begin
    cls.node_a = node_a;
    cls.node_b = node_b;
    cls.cost   = edge_cost & COST_MASK;
    if (cmd == CMD_CLEAR) begin
      cls.op = OP_CLEAR;
    end else if ({1'b0, node_a} >= node_count || {1'b0, node_b} >= node_count) begin
      cls.op = OP_BAD;
    end else begin
      cls.op = OP_EDGE;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= cls;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (q_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({push, q_pop})
        2'b10:   fill <= fill + 2'd1;
        2'b01:   fill <= fill - 2'd1;
        default: fill <= fill;
      endcase
    end
  end

endmodule

`default_nettype wire

### sv/kuf_back.sv
// ----------------------------------------------------------------------------
// kuf_back
// Union-find sequencer: parent/size memory, root walks, compression, merge.
// ----------------------------------------------------------------------------
`default_nettype none

module kuf_back #(
  parameter int MAX_NODES = 1024
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        restart,
  input  wire logic [kuf_pkg::COUNT_W-1:0] node_count,
  input  wire logic                        q_valid,
  input  wire kuf_pkg::item_t              q_item,
  output      logic                        q_pop,
  output      logic                        out_valid,
  input  wire logic                        out_ready,
  output      logic                        edge_taken,
  output      logic [kuf_pkg::TOTAL_W-1:0] total_cost,
  output      logic [kuf_pkg::COUNT_W-1:0] components_left,
  output      logic                        all_connected,
  output      logic                        bad_edge
);
  import kuf_pkg::*;

  localparam int IW = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
  localparam int SW = IW + 1;
  localparam logic [IW-1:0] LAST = IW'(MAX_NODES - 1);

  typedef enum logic [6:0] {
    S_CLR    = 7'b0000001,
    S_IDLE   = 7'b0000010,
    S_RD     = 7'b0000100,
    S_CHK    = 7'b0001000,
    S_LINK_L = 7'b0010000,
    S_LINK_W = 7'b0100000,
    S_DONE   = 7'b1000000
  } state_t;

  typedef enum logic [3:0] {
    P_FIND_A = 4'b0001,
    P_FIND_B = 4'b0010,
    P_COMP_A = 4'b0100,
    P_COMP_B = 4'b1000
  } phase_t;

  // entry: {size, parent}
  logic [SW+IW-1:0] mem [MAX_NODES];
  logic [SW+IW-1:0] rd_q;
  logic             we;
  logic [IW-1:0]    wa;
  logic [SW+IW-1:0] wd;

  state_t         state;
  phase_t         phase;
  logic [IW-1:0]  cnt;
  logic           clr_reply;
  logic [IW-1:0]  x;
  logic [IW-1:0]  na;
  logic [IW-1:0]  nb;
  logic [COST_W-1:0] cost;
  logic [IW-1:0]  ra;
  logic [IW-1:0]  rb;
  logic [SW-1:0]  sa;
  logic [SW-1:0]  sb;
  logic [IW-1:0]  win;
  logic [IW-1:0]  lose;
  logic [SW-1:0]  lose_size;
  logic           taken;
  logic           bad;
  logic [COUNT_W-1:0] comp;
  logic [TOTAL_W-1:0] cost_sum;
  logic [TOTAL_W:0]   sum_wide;

  logic [IW-1:0]  par;
  logic [SW-1:0]  size;
  logic           is_root;
  logic           out_free;
  logic           fire;

  assign par      = rd_q[IW-1:0];
  assign size     = rd_q[SW+IW-1:IW];
  assign is_root  = (par == x);
  assign out_free = !out_valid || out_ready;
  assign fire     = (state == S_DONE) && out_free;
  assign q_pop    = (state == S_IDLE) && q_valid;
  assign sum_wide = {1'b0, cost_sum} + (TOTAL_W+1)'(cost);

  // write port
  always_comb begin
    we = 1'b0;
    wa = x;
    wd = {size, win};
    case (state)
      S_CLR: begin
        we = 1'b1;
        wa = cnt;
        wd = {SW'(1), cnt};
      end
      S_CHK: begin
        we = !is_root && ((phase == P_COMP_A) || (phase == P_COMP_B));
      end
      S_LINK_L: begin
        we = 1'b1;
        wa = lose;
        wd = {lose_size, win};
      end
      S_LINK_W: begin
        we = 1'b1;
        wa = win;
        wd = {sa + sb, win};
      end
      default: we = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rd_q <= mem[x];
  end

  always_ff @(posedge clk) begin
    if (rst || restart) begin
      state     <= S_CLR;
      cnt       <= '0;
      clr_reply <= 1'b0;
      out_valid <= 1'b0;
      phase     <= P_FIND_A;
    end else begin
      if (fire) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_CLR: begin
          cnt <= cnt + IW'(1);
          if (cnt == LAST) begin
            comp     <= node_count;
            cost_sum <= '0;
            state    <= clr_reply ? S_DONE : S_IDLE;
          end
        end
        S_IDLE: begin
          if (q_valid) begin
            na    <= IW'(q_item.node_a);
            nb    <= IW'(q_item.node_b);
            cost  <= q_item.cost;
            taken <= 1'b0;
            bad   <= 1'b0;
            case (q_item.op)
              OP_CLEAR: begin
                cnt       <= '0;
                clr_reply <= 1'b1;
                state     <= S_CLR;
              end
              OP_BAD: begin
                bad   <= 1'b1;
                state <= S_DONE;
              end
              OP_EDGE: begin
                if (comp > COUNT_W'(1)) begin
                  x     <= IW'(q_item.node_a);
                  phase <= P_FIND_A;
                  state <= S_RD;
                end else begin
                  state <= S_DONE;
                end
              end
              default: state <= S_DONE;
            endcase
          end
        end
        S_RD: begin
          state <= S_CHK;
        end
        S_CHK: begin
          state <= S_RD;
          if (!is_root) begin
            x <= par;
          end else begin
            case (phase)
              P_FIND_A: begin
                ra    <= x;
                sa    <= size;
                x     <= nb;
                phase <= P_FIND_B;
              end
              P_FIND_B: begin
                rb <= x;
                sb <= size;
                // smaller set goes under the larger; ties keep node_a's root
                if (sa < size) begin
                  win       <= x;
                  lose      <= ra;
                  lose_size <= sa;
                end else begin
                  win       <= ra;
                  lose      <= x;
                  lose_size <= size;
                end
                x     <= na;
                phase <= P_COMP_A;
              end
              P_COMP_A: begin
                x     <= nb;
                phase <= P_COMP_B;
              end
              P_COMP_B: begin
                state <= (ra != rb) ? S_LINK_L : S_DONE;
              end
              default: state <= S_DONE;
            endcase
          end
        end
        S_LINK_L: begin
          state <= S_LINK_W;
        end
        S_LINK_W: begin
          comp     <= comp - COUNT_W'(1);
          cost_sum <= sum_wide[TOTAL_W] ? TOTAL_MAX : sum_wide[TOTAL_W-1:0];
          taken    <= 1'b1;
          state    <= S_DONE;
        end
        S_DONE: begin
          if (out_free) begin
            edge_taken      <= taken;
            total_cost      <= cost_sum;
            components_left <= comp;
            all_connected   <= (comp == COUNT_W'(1));
            bad_edge        <= bad;
            clr_reply       <= 1'b0;
            state           <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

### sv/kruskal_union_find_edge_filter.sv
// ----------------------------------------------------------------------------
// kruskal_union_find_edge_filter
// Disjoint-set forest that decides which edges join a minimum spanning tree.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready): one item per edge in ascending cost
//   order, or a clear command (cmd = 1) that restarts the graph.
//   Output channel (out_valid/out_ready): exactly one result item per input
//   item, in order: edge_taken, saturating total_cost, components_left,
//   all_connected and bad_edge.
//   Config: cfg_we writes node_count (saturated to 1..MAX_NODES) from
//   cfg_data and clears the graph; write only while the block is idle.
// Sequencing:
//   Each node visited on a root walk or a compression walk takes a memory
//   read, then a check of the registered data. An edge walks both paths
//   twice (root walks, then compression walks), and a merge adds a link
//   write for the losing root and a size write for the winning root. Bad
//   edges and edges after the graph is connected skip the walks. A clear
//   command, a config write and reset each run a clearing pass over every
//   entry of the parent/size memory; queued items wait.
// Stalls:
//   A two-entry queue sits between the classifying front end and the
//   sequencer, and the result lives in an output register, so while a result
//   waits on out_ready three more items are taken, then in_ready drops.
// ----------------------------------------------------------------------------
`default_nettype none

module kruskal_union_find_edge_filter #(
  parameter int MAX_NODES = 1024,
  parameter int COST_BITS = 32
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        cfg_we,
  input  wire logic [kuf_pkg::COUNT_W-1:0] cfg_data,
  input  wire logic                        in_valid,
  output      logic                        in_ready,
  input  wire logic                        cmd,
  input  wire logic [kuf_pkg::NODE_W-1:0]  node_a,
  input  wire logic [kuf_pkg::NODE_W-1:0]  node_b,
  input  wire logic [kuf_pkg::COST_W-1:0]  edge_cost,
  output      logic                        out_valid,
  input  wire logic                        out_ready,
  output      logic                        edge_taken,
  output      logic [kuf_pkg::TOTAL_W-1:0] total_cost,
  output      logic [kuf_pkg::COUNT_W-1:0] components_left,
  output      logic                        all_connected,
  output      logic                        bad_edge
);
  import kuf_pkg::*;

  // node_count reset value, clipped to the memory size
  localparam logic [COUNT_W-1:0] NC_RST =
    (MAX_NODES < 1024) ? COUNT_W'(MAX_NODES) : COUNT_W'(1024);

  logic [COUNT_W-1:0] node_count;
  logic [COUNT_W-1:0] node_count_next;
  logic               q_valid;
  item_t              q_item;
  logic               q_pop;

  // saturate writes to 1..MAX_NODES
  always_comb begin
    if (cfg_data == '0) begin
      node_count_next = COUNT_W'(1);
    end else if (32'(cfg_data) > 32'(MAX_NODES)) begin
      node_count_next = COUNT_W'(MAX_NODES);
    end else begin
      node_count_next = cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      node_count <= NC_RST;
    end else if (cfg_we) begin
      node_count <= node_count_next;
    end
  end

  kuf_front #(
    .COST_BITS (COST_BITS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .cmd        (cmd),
    .node_a     (node_a),
    .node_b     (node_b),
    .edge_cost  (edge_cost),
    .node_count (node_count),
    .q_valid    (q_valid),
    .q_item     (q_item),
    .q_pop      (q_pop)
  );

  kuf_back #(
    .MAX_NODES (MAX_NODES)
  ) u_back (
    .clk             (clk),
    .rst             (rst),
    .restart         (cfg_we),
    .node_count      (node_count),
    .q_valid         (q_valid),
    .q_item          (q_item),
    .q_pop           (q_pop),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .edge_taken      (edge_taken),
    .total_cost      (total_cost),
    .components_left (components_left),
    .all_connected   (all_connected),
    .bad_edge        (bad_edge)
  );

endmodule

`default_nettype wire

### verif/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the Kruskal union-find edge filter: drives edges
// and clears, predicts every result with a private disjoint-set forest and
// compares each output item field by field, in order.
// ----------------------------------------------------------------------------
`default_nettype none

// Scoreboard: shadow forest plus the queue of predicted results.
class mst_scoreboard;
  typedef struct {
    bit        taken;
    bit [47:0] total;
    bit [10:0] comps;
    bit        joined;
    bit        bad;
  } mst_result_t;

  int unsigned link[1024];
  int unsigned setsz[1024];
  int unsigned comps;
  bit [48:0]   total;
  int unsigned nodes;
  mst_result_t due[$];
  int          errors;
  int          n_taken, n_bad, n_clear, n_checked;

  function void restart();
    for (int i = 0; i < 1024; i++) begin
      link[i]  = i;
      setsz[i] = 1;
    end
    comps = nodes;
    total = '0;
  endfunction

  // register write: saturate to 1..1024, then clear
  function void set_nodes(bit [10:0] v);
    nodes = (v == 0) ? 1 : ((v > 1024) ? 1024 : v);
    restart();
  endfunction

  function int unsigned find_root(int unsigned x);
    int unsigned n;
    n = 0;
    while (link[x] != x && n < 1024) begin
      x = link[x];
      n++;
    end
    return x;
  endfunction

  // point every node on the walk at tgt
  function void squash(int unsigned x, int unsigned tgt);
    int unsigned n, nx;
    n = 0;
    while (link[x] != x && n < 1024) begin
      nx      = link[x];
      link[x] = tgt;
      x       = nx;
      n++;
    end
  endfunction

  // accepted input item: work out its result
  function void note_item(bit cmd, bit [9:0] a, bit [9:0] b, bit [31:0] cost);
    mst_result_t r;
    int unsigned ra, rb, win, lose;
    r.taken = 0;
    r.bad   = 0;
    if (cmd == kuf_pkg::CMD_CLEAR) begin
      restart();
      n_clear++;
    end else if (a >= nodes || b >= nodes) begin
      r.bad = 1;
      n_bad++;
    end else if (comps > 1) begin
      ra = find_root(a);
      rb = find_root(b);
      if (ra == rb) begin
        squash(a, ra);
        squash(b, rb);
      end else begin
        win  = ra;
        lose = rb;
        if (setsz[ra] < setsz[rb]) begin
          win  = rb;
          lose = ra;
        end
        squash(a, win);
        squash(b, win);
        link[lose]  = win;
        setsz[win] += setsz[lose];
        comps--;
        total += cost;
        if (total > kuf_pkg::TOTAL_MAX) total = kuf_pkg::TOTAL_MAX;
        r.taken = 1;
        n_taken++;
      end
    end
    r.total  = total[47:0];
    r.comps  = 11'(comps);
    r.joined = (comps == 1);
    due.insert(due.size(), r);
  endfunction

  function void check_result(bit taken, bit [47:0] tot, bit [10:0] cl, bit ac, bit bad);
    mst_result_t e;
    if (due.size() == 0) begin
      $display("%0t: unexpected result item taken=%0d total=%0d comps=%0d",
               $time, taken, tot, cl);
      errors++;
      return;
    end
    e = due.pop_front();
    n_checked++;
    if (taken !== e.taken) begin
      $display("%0t: edge_taken exp %0d got %0d", $time, e.taken, taken);
      errors++;
    end
    if (tot !== e.total) begin
      $display("%0t: total_cost exp %0d got %0d", $time, e.total, tot);
      errors++;
    end
    if (cl !== e.comps) begin
      $display("%0t: components_left exp %0d got %0d", $time, e.comps, cl);
      errors++;
    end
    if (ac !== e.joined) begin
      $display("%0t: all_connected exp %0d got %0d", $time, e.joined, ac);
      errors++;
    end
    if (bad !== e.bad) begin
      $display("%0t: bad_edge exp %0d got %0d", $time, e.bad, bad);
      errors++;
    end
  endfunction
endclass

module tb_top;
  import kuf_pkg::*;

  localparam int CYCLE_LIMIT = 2000000;

  logic               clk = 0;
  logic               rst = 1;
  logic               cfg_we = 0;
  logic [COUNT_W-1:0] cfg_data = '0;
  logic               in_valid = 0;
  logic               in_ready;
  logic               cmd = 0;
  logic [NODE_W-1:0]  node_a = '0;
  logic [NODE_W-1:0]  node_b = '0;
  logic [COST_W-1:0]  edge_cost = '0;
  logic               out_valid;
  logic               out_ready = 0;
  logic               edge_taken;
  logic [TOTAL_W-1:0] total_cost;
  logic [COUNT_W-1:0] components_left;
  logic               all_connected;
  logic               bad_edge;

  mst_scoreboard sb;
  int unsigned   cycles = 0;
  bit            quiet = 0;   // no idling on either side near the end
  int unsigned   n_items = 0;
  bit [31:0]     run_cost;

  always begin
    #2 clk = 1;
    #2 clk = 0;
  end

  kruskal_union_find_edge_filter u_top (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready),
    .cmd(cmd), .node_a(node_a), .node_b(node_b), .edge_cost(edge_cost),
    .out_valid(out_valid), .out_ready(out_ready),
    .edge_taken(edge_taken), .total_cost(total_cost),
    .components_left(components_left), .all_connected(all_connected),
    .bad_edge(bad_edge)
  );

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // result monitor, sampled at the rising edge
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready)
      sb.check_result(edge_taken, total_cost, components_left, all_connected, bad_edge);
  end

  // receiver: drops out_ready in random bursts while not quiet
  int unsigned hold = 0;
  always @(negedge clk) begin
    if (hold > 0) begin
      hold--;
      out_ready <= 0;
    end else if (!quiet && $urandom_range(0, 9) == 0) begin
      hold = $urandom_range(0, 2);
      out_ready <= 0;
    end else begin
      out_ready <= 1;
    end
  end

  // one item; valid is held until the rising edge that takes it and only
  // drops for an idle gap or at the end of a burst of items
  task automatic send_item(bit c, bit [9:0] a, bit [9:0] b, bit [31:0] cost);
    if (!quiet && $urandom_range(0, 7) == 0) begin
      in_valid <= 0;
      repeat ($urandom_range(1, 3)) @(negedge clk);
    end
    cmd       <= c;
    node_a    <= a;
    node_b    <= b;
    edge_cost <= cost;
    in_valid  <= 1;
    do @(posedge clk); while (!in_ready);
    sb.note_item(c, a, b, cost);
    n_items++;
    @(negedge clk);
  endtask

  // wait for every expected result, then let the block settle
  task automatic drain();
    in_valid <= 0;
    while (sb.due.size() != 0) @(negedge clk);
    repeat (40) @(negedge clk);
  endtask

  task automatic write_nodes(bit [10:0] v);
    drain();
    cfg_we   <= 1;
    cfg_data <= v;
    @(negedge clk);
    cfg_we <= 0;
    sb.set_nodes(v);
    run_cost = 0;
  endtask

  // random edges: mostly valid endpoints with rising cost, some noise
  task automatic random_edges(int count);
    int unsigned r, n;
    bit [9:0] a, b;
    n = sb.nodes;
    for (int k = 0; k < count; k++) begin
      r = $urandom_range(0, 99);
      if (r < 2) begin
        send_item(CMD_CLEAR, 10'($urandom), 10'($urandom), $urandom);
        run_cost = $urandom_range(0, 3) == 0 ? $urandom >> 1 : 0;
        continue;
      end
      a = 10'($urandom_range(0, n - 1));
      b = 10'($urandom_range(0, n - 1));
      if (r < 8) begin
        if (n < 1024) begin
          if (r & 1) a = 10'($urandom_range(n, 1023));
          else       b = 10'($urandom_range(n, 1023));
        end else begin
          a = 10'($urandom);
          b = 10'($urandom);
        end
      end
      if (r == 99) run_cost = $urandom;
      else         run_cost = run_cost + $urandom_range(0, 5000);
      send_item(CMD_EDGE, a, b, run_cost);
    end
  endtask

  bit [10:0] settings[10] = '{1024, 2047, 0, 2, 7, 33, 300, 1024, 1500, 1};

  initial begin
    sb = new();
    sb.nodes = 1024;
    sb.restart();
    repeat (12) @(negedge clk);
    rst <= 0;
    // let the clearing pass after reset finish
    repeat (1100) @(negedge clk);

    // directed: four nodes
    write_nodes(4);
    send_item(CMD_EDGE, 0, 0, 1);              // self loop
    send_item(CMD_EDGE, 0, 1, 0);
    send_item(CMD_EDGE, 2, 3, 5);
    send_item(CMD_EDGE, 1, 0, 6);              // same set
    send_item(CMD_EDGE, 4, 0, 7);              // bad first end
    send_item(CMD_EDGE, 0, 1023, 8);           // bad second end
    send_item(CMD_EDGE, 1023, 1023, 8);
    send_item(CMD_EDGE, 3, 1, 32'hFFFF_FFFF);  // joins the last two sets
    send_item(CMD_EDGE, 1, 3, 32'hFFFF_FFFF);  // graph done: ignored
    send_item(CMD_CLEAR, 10'h3FF, 10'h3FF, 32'hFFFF_FFFF);
    send_item(CMD_EDGE, 3, 2, 32'hFFFF_FFFF);
    send_item(CMD_EDGE, 2, 1, 32'hFFFF_FFFF);
    send_item(CMD_EDGE, 0, 3, 32'hFFFF_FFFF);
    // full size: highest node indices
    write_nodes(1024);
    send_item(CMD_EDGE, 1023, 0, 3);
    send_item(CMD_EDGE, 10'h155, 10'h2AA, 4);
    send_item(CMD_EDGE, 1023, 10'h2AA, 32'h8000_0000);
    // single node: already connected from the start
    write_nodes(1);
    send_item(CMD_EDGE, 0, 0, 9);
    send_item(CMD_EDGE, 1, 0, 9);

    foreach (settings[i]) begin
      write_nodes(settings[i]);
      if (i == 9) quiet = 1;
      random_edges(i == 9 ? 60 : 190);
    end

    drain();
    $display("%0d items: %0d edges taken, %0d bad, %0d clears; %0d results checked",
             n_items, sb.n_taken, sb.n_bad, sb.n_clear, sb.n_checked);
    $display("node counts swept from 1 to 1024 including saturated writes");
    if (sb.errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end
endmodule

`default_nettype wire
